FILE: rtl/mafb_pkg.sv
package mafb_pkg;

    localparam int PIX_W  = 32;
    localparam int BYTE_W = 8;
    localparam int MODE_W = 3;
    localparam int IDX_W  = 3;

    // pixel format modes (bytes per pixel)
    localparam logic [MODE_W-1:0] MODE_16BPP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_24BPP = 3'd3;
    localparam logic [MODE_W-1:0] MODE_32BPP = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] bytes_per_pixel;
        logic [PIX_W-1:0]  red_mask;
        logic [PIX_W-1:0]  green_mask;
        logic [PIX_W-1:0]  blue_mask;
        logic [PIX_W-1:0]  alpha_mask;
        logic [PIX_W-1:0]  fill_color;
        logic [BYTE_W-1:0] blend_alpha;
        logic [BYTE_W-1:0] byte_lanes;
    } mafb_cfg_t;

    // d + ((s - d) * a >> 8), all modulo 2^32, then masked
    function automatic logic [PIX_W-1:0] masked_channel(
        input logic [PIX_W-1:0]  p,
        input logic [PIX_W-1:0]  c,
        input logic [PIX_W-1:0]  m,
        input logic [BYTE_W-1:0] a
    );
        logic [PIX_W-1:0] d;
        logic [PIX_W-1:0] s;
        logic [PIX_W-1:0] delta;
        d     = p & m;
        s     = c & m;
        delta = PIX_W'((s - d) * {{(PIX_W-BYTE_W){1'b0}}, a});
        return (d + (delta >> BYTE_W)) & m;
    endfunction

    // byte blend with floor shift; bits 15:8 of the product are the same
    // in 16-bit wrapping arithmetic as in signed arithmetic
    function automatic logic [BYTE_W-1:0] lane_blend(
        input logic [BYTE_W-1:0] dst,
        input logic [BYTE_W-1:0] src,
        input logic [BYTE_W-1:0] a
    );
        logic [2*BYTE_W-1:0] diff;
        logic [2*BYTE_W-1:0] prod;
        diff = {{BYTE_W{1'b0}}, src} - {{BYTE_W{1'b0}}, dst};
        prod = (2*BYTE_W)'(diff * {{BYTE_W{1'b0}}, a});
        return dst + prod[2*BYTE_W-1:BYTE_W];
    endfunction

endpackage

FILE: rtl/mafb_datapath.sv
module mafb_datapath (
    input  mafb_pkg::mafb_cfg_t       cfg,
    input  logic [mafb_pkg::PIX_W-1:0] pixel,
    output logic [mafb_pkg::PIX_W-1:0] result
);
    import mafb_pkg::*;

    localparam int NCH   = 4;  // red, green, blue, alpha
    localparam int NLANE = 3;  // writable byte lanes in 24-bit mode

    logic [PIX_W-1:0]  p;
    logic [PIX_W-1:0]  masked_res;
    logic [BYTE_W-1:0] src_byte [NCH];
    logic [BYTE_W-1:0] dst_byte [NCH];
    logic [BYTE_W-1:0] val      [NCH];
    logic [1:0]        lane     [NCH];
    logic [BYTE_W-1:0] lane_in  [NCH];
    logic [BYTE_W-1:0] lane_out [NLANE];

    // masked modes; a zero alpha mask already yields zero alpha
    always_comb
    begin
        p = (cfg.bytes_per_pixel == MODE_16BPP) ? {16'd0, pixel[15:0]} : pixel;
        masked_res =
            masked_channel(p, cfg.fill_color, cfg.red_mask,   cfg.blend_alpha) |
            masked_channel(p, cfg.fill_color, cfg.green_mask, cfg.blend_alpha) |
            masked_channel(p, cfg.fill_color, cfg.blue_mask,  cfg.blend_alpha) |
            masked_channel(p, cfg.fill_color, cfg.alpha_mask, cfg.blend_alpha);
    end

    // byte lane mode
    always_comb
    begin
        for (int k = 0; k < NLANE; k++) begin
            lane_in[k] = pixel[k*BYTE_W +: BYTE_W];
        end
        lane_in[NLANE] = '0;  // lane 3 reads zero
        for (int c = 0; c < NCH; c++) begin
            lane[c]     = cfg.byte_lanes[2*c +: 2];
            src_byte[c] = cfg.fill_color[lane[c]*BYTE_W +: BYTE_W];
            dst_byte[c] = lane_in[lane[c]];
            val[c]      = lane_blend(dst_byte[c], src_byte[c], cfg.blend_alpha);
        end
        // later channel wins a shared lane; lane 3 writes are dropped
        for (int k = 0; k < NLANE; k++) begin
            lane_out[k] = lane_in[k];
            for (int c = 0; c < NCH; c++) begin
                if (lane[c] == 2'(k)) begin
                    lane_out[k] = val[c];
                end
            end
        end
    end

    always_comb
    begin
        case (cfg.bytes_per_pixel)
            MODE_16BPP: result = {16'd0, masked_res[15:0]};
            MODE_32BPP: result = masked_res;
            MODE_24BPP: result = {8'd0, lane_out[2], lane_out[1], lane_out[0]};
            default:    result = pixel;
        endcase
    end

endmodule

FILE: rtl/masked_alpha_fill_blend_unit.sv
// An accepted pixel is held in the input register, then the result register drives pixel_out.
// One item per cycle while out_ready is high; the datapath is a single combinational pass.
// An input register and a result register act as a two-slot buffer, so one
// item is still accepted while a finished result waits on out_ready.
// Reset (rst_n low, asynchronous): both slots empty, config registers to defaults.
module masked_alpha_fill_blend_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [mafb_pkg::IDX_W-1:0]    cfg_index,
    input  logic [mafb_pkg::PIX_W-1:0]    cfg_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mafb_pkg::PIX_W-1:0]    pixel_in,
    // output channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mafb_pkg::PIX_W-1:0]    pixel_out
);
    import mafb_pkg::*;

    // register indexes
    localparam logic [IDX_W-1:0] REG_BPP         = 3'd0;
    localparam logic [IDX_W-1:0] REG_RED_MASK    = 3'd1;
    localparam logic [IDX_W-1:0] REG_GREEN_MASK  = 3'd2;
    localparam logic [IDX_W-1:0] REG_BLUE_MASK   = 3'd3;
    localparam logic [IDX_W-1:0] REG_ALPHA_MASK  = 3'd4;
    localparam logic [IDX_W-1:0] REG_FILL_COLOR  = 3'd5;
    localparam logic [IDX_W-1:0] REG_BLEND_ALPHA = 3'd6;
    localparam logic [IDX_W-1:0] REG_BYTE_LANES  = 3'd7;

    mafb_cfg_t        cfg_reg;
    mafb_cfg_t        cfg_next;

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pixel_reg;
    logic [PIX_W-1:0] blend_result;
    logic             out_load;
    logic             s1_load;

    // ---------------- configuration registers ----------------
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_BPP:         cfg_next.bytes_per_pixel = cfg_data[MODE_W-1:0];
                REG_RED_MASK:    cfg_next.red_mask        = cfg_data;
                REG_GREEN_MASK:  cfg_next.green_mask      = cfg_data;
                REG_BLUE_MASK:   cfg_next.blue_mask       = cfg_data;
                REG_ALPHA_MASK:  cfg_next.alpha_mask      = cfg_data;
                REG_FILL_COLOR:  cfg_next.fill_color      = cfg_data;
                REG_BLEND_ALPHA: cfg_next.blend_alpha     = cfg_data[BYTE_W-1:0];
                REG_BYTE_LANES:  cfg_next.byte_lanes      = cfg_data[BYTE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.bytes_per_pixel <= MODE_32BPP;
            cfg_reg.red_mask        <= 32'h00ff_0000;
            cfg_reg.green_mask      <= 32'h0000_ff00;
            cfg_reg.blue_mask       <= 32'h0000_00ff;
            cfg_reg.alpha_mask      <= '0;
            cfg_reg.fill_color      <= '0;
            cfg_reg.blend_alpha     <= '0;
            cfg_reg.byte_lanes      <= 8'd6;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- pipeline control ----------------
    // result register loads from a full input register when it is empty or being drained this cycle;
    // input register accepts when empty or moving forward this cycle
    assign out_load = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || out_load;
    assign s1_load  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s1_load) begin
            s1_pixel_reg <= pixel_in;
        end
        if (out_load) begin
            out_pixel_reg <= blend_result;
        end
    end

    // ---------------- blend datapath ----------------
    mafb_datapath u_datapath (
        .cfg    (cfg_reg),
        .pixel  (s1_pixel_reg),
        .result (blend_result)
    );

    assign out_valid = out_valid_reg;
    assign pixel_out = out_pixel_reg;

endmodule

FILE: rtl/mafb_checker.sv
module mafb_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [mafb_pkg::PIX_W-1:0] pixel_out
);
    import mafb_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out))
        else $error("pixel_out changed while stalled");

    // input only blocks when both slots are full and the output is stalled
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low with free slot");

    // a new result traces back to an accepted item, through the input register and the result register
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without an accepted item");

    // accepting into the last free slot closes the input
    a_fill_block: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_valid && !out_ready |=> !in_ready || out_ready)
        else $error("input open with both slots full");

endmodule

bind masked_alpha_fill_blend_unit mafb_checker u_mafb_checker (.*);

FILE: sim/mafb_tb_pkg.sv
package mafb_tb_pkg;

    // configuration register indexes, in port order
    typedef enum logic [mafb_pkg::IDX_W-1:0] {
        REG_BYTES_PER_PIXEL = 3'd0,
        REG_RED_MASK        = 3'd1,
        REG_GREEN_MASK      = 3'd2,
        REG_BLUE_MASK       = 3'd3,
        REG_ALPHA_MASK      = 3'd4,
        REG_FILL_COLOR      = 3'd5,
        REG_BLEND_ALPHA     = 3'd6,
        REG_BYTE_LANES      = 3'd7
    } cfg_reg_e;

    // format codes with no blending: the pixel passes through
    localparam logic [mafb_pkg::MODE_W-1:0] MODE_RAW_LO = 3'd0;
    localparam logic [mafb_pkg::MODE_W-1:0] MODE_RAW_HI = 3'd7;

endpackage

FILE: sim/fill_blend_checker.sv
module fill_blend_checker
    import mafb_pkg::*, mafb_tb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [PIX_W-1:0]  cfg_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [PIX_W-1:0]  pixel_in,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [PIX_W-1:0]  pixel_out,
    output int                outstanding,
    output int                fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] LANE_DEAD = 2'd3;

    mafb_cfg_t        shadow;
    logic [PIX_W-1:0] expected_pixels[$];
    logic [PIX_W-1:0] want;
    int               n_err = 0;

    function automatic logic [PIX_W-1:0] mix_channel(
        input logic [PIX_W-1:0] p,
        input logic [PIX_W-1:0] m
    );
        logic [PIX_W-1:0] d;
        logic [PIX_W-1:0] s;
        logic [PIX_W-1:0] delta;
        d     = p & m;
        s     = shadow.fill_color & m;
        delta = (s - d) * PIX_W'(shadow.blend_alpha);
        return (d + (delta >> BYTE_W)) & m;
    endfunction

    // signed difference, floor shift
    function automatic logic [BYTE_W-1:0] mix_lane(
        input logic [BYTE_W-1:0] dst,
        input logic [BYTE_W-1:0] src
    );
        int diff;
        int prod;
        diff = int'(src) - int'(dst);
        prod = diff * int'(shadow.blend_alpha);
        return BYTE_W'(int'(dst) + (prod >>> BYTE_W));
    endfunction

    function automatic logic [PIX_W-1:0] blend_pixel(input logic [PIX_W-1:0] pix);
        logic [PIX_W-1:0]  p;
        logic [PIX_W-1:0]  res;
        logic [PIX_W-1:0]  a_part;
        logic [BYTE_W-1:0] lanes_in[4];
        logic [BYTE_W-1:0] lanes_out[4];
        logic [BYTE_W-1:0] mixed[4];
        logic [1:0]        pos[4];
        case (shadow.bytes_per_pixel)
            MODE_16BPP, MODE_32BPP:
            begin
                p = (shadow.bytes_per_pixel == MODE_16BPP) ? {16'h0, pix[15:0]} : pix;
                a_part = (shadow.alpha_mask != '0) ? mix_channel(p, shadow.alpha_mask) : '0;
                res = mix_channel(p, shadow.red_mask) | mix_channel(p, shadow.green_mask)
                    | mix_channel(p, shadow.blue_mask) | a_part;
                if (shadow.bytes_per_pixel == MODE_16BPP)
                    res[31:16] = '0;
            end
            MODE_24BPP:
            begin
                for (int c = 0; c < 4; c++)
                    lanes_in[c] = (c < 3) ? pix[BYTE_W*c +: BYTE_W] : '0;
                for (int c = 0; c < 4; c++)
                begin
                    pos[c]   = shadow.byte_lanes[2*c +: 2];
                    mixed[c] = mix_lane(lanes_in[pos[c]],
                                        shadow.fill_color[BYTE_W*pos[c] +: BYTE_W]);
                end
                lanes_out = lanes_in;
                for (int c = 0; c < 4; c++)
                    if (pos[c] != LANE_DEAD)
                        lanes_out[pos[c]] = mixed[c];
                res = {8'h0, lanes_out[2], lanes_out[1], lanes_out[0]};
            end
            default:
                res = pix;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow.bytes_per_pixel = MODE_32BPP;
            shadow.red_mask        = 32'h00ff_0000;
            shadow.green_mask      = 32'h0000_ff00;
            shadow.blue_mask       = 32'h0000_00ff;
            shadow.alpha_mask      = '0;
            shadow.fill_color      = '0;
            shadow.blend_alpha     = '0;
            shadow.byte_lanes      = 8'h06;
            expected_pixels.delete();
            outstanding <= 0;
            fail_count  <= n_err;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_e'(cfg_index))
                    REG_BYTES_PER_PIXEL: shadow.bytes_per_pixel = cfg_data[MODE_W-1:0];
                    REG_RED_MASK:        shadow.red_mask        = cfg_data;
                    REG_GREEN_MASK:      shadow.green_mask      = cfg_data;
                    REG_BLUE_MASK:       shadow.blue_mask       = cfg_data;
                    REG_ALPHA_MASK:      shadow.alpha_mask      = cfg_data;
                    REG_FILL_COLOR:      shadow.fill_color      = cfg_data;
                    REG_BLEND_ALPHA:     shadow.blend_alpha     = cfg_data[BYTE_W-1:0];
                    REG_BYTE_LANES:      shadow.byte_lanes      = cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    n_err++;
                    $display("%0t: pixel_out %08h with no item outstanding", $time, pixel_out);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_out !== want)
                    begin
                        n_err++;
                        $display("%0t: pixel_out mismatch: expected %08h, got %08h",
                                 $time, want, pixel_out);
                    end
                end
            end
            if (in_valid && in_ready)
                expected_pixels.push_back(blend_pixel(pixel_in));
            outstanding <= expected_pixels.size();
            fail_count  <= n_err;
        end
    end

endmodule

FILE: sim/masked_alpha_fill_blend_unit_tb.sv
module masked_alpha_fill_blend_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mafb_pkg::*;
    import mafb_tb_pkg::*;

    // block ports; every input has a known value from time zero
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [PIX_W-1:0]  cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [PIX_W-1:0]  pixel_in  = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [PIX_W-1:0]  pixel_out;

    int outstanding;
    int fail_count;

    // idle odds in percent; sender's is used only by the stimulus process
    int send_idle = 12;
    int recv_idle = 59;

    // long receiver hold-off: raising stall_phase starts one
    int stall_phase = -1;
    int held_phase  = -1;
    int hold_left   = 0;

    int phase;
    int n;

    always #6 clk = ~clk;

    masked_alpha_fill_blend_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out)
    );

    fill_blend_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_in    (pixel_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_out   (pixel_out),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    // Receiver: random back-pressure, plus a receiver hold-off on request.
    // While held, the sender keeps offering, so both slots fill and
    // in_ready drops.
    always @(posedge clk)
    begin
        if (stall_phase != held_phase)
        begin
            held_phase <= stall_phase;
            hold_left  <= 300;
            out_ready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // One register write per cycle; cfg_we stays high across a burst and
    // drops in end_writes.
    task automatic write_reg(input cfg_reg_e idx, input logic [PIX_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Full register set. Narrow registers get random junk above their width
    // half the time; the block must ignore it.
    task automatic apply_cfg(
        input logic [MODE_W-1:0] mode,
        input logic [PIX_W-1:0]  r,
        input logic [PIX_W-1:0]  g,
        input logic [PIX_W-1:0]  b,
        input logic [PIX_W-1:0]  a,
        input logic [PIX_W-1:0]  fill,
        input logic [BYTE_W-1:0] alpha,
        input logic [BYTE_W-1:0] lanes
    );
        logic [PIX_W-1:0] hi;
        hi = ($urandom_range(1) != 0) ? PIX_W'($urandom) : '0;
        write_reg(REG_BYTES_PER_PIXEL, {hi[PIX_W-1:MODE_W], mode});
        write_reg(REG_RED_MASK, r);
        write_reg(REG_GREEN_MASK, g);
        write_reg(REG_BLUE_MASK, b);
        write_reg(REG_ALPHA_MASK, a);
        write_reg(REG_FILL_COLOR, fill);
        write_reg(REG_BLEND_ALPHA, {hi[PIX_W-1:BYTE_W], alpha});
        write_reg(REG_BYTE_LANES, {hi[PIX_W-1:BYTE_W], lanes});
        end_writes();
    endtask

    // Called in a clock step; returns in the step of the accepting edge.
    // in_valid is only ever assigned once per step.
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= pix;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Sender pauses until every result is back. outstanding is registered in
    // the checker, hence the first wait.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic random_setup();
        logic [MODE_W-1:0] mode;
        logic [PIX_W-1:0]  r;
        logic [PIX_W-1:0]  g;
        logic [PIX_W-1:0]  b;
        logic [PIX_W-1:0]  a;
        logic [PIX_W-1:0]  fill;
        logic [BYTE_W-1:0] alpha;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 35)
            mode = MODE_32BPP;
        else if (pick < 60)
            mode = MODE_16BPP;
        else if (pick < 90)
            mode = MODE_24BPP;
        else
        begin
            // pass-through codes
            mode = MODE_W'($urandom_range(7));
            while (mode == MODE_16BPP || mode == MODE_24BPP || mode == MODE_32BPP)
                mode = MODE_W'($urandom_range(7));
        end
        case ($urandom_range(4))
            0:
            begin
                r = 32'h00ff_0000; g = 32'h0000_ff00; b = 32'h0000_00ff; a = 32'hff00_0000;
            end
            1:
            begin
                r = 32'h0000_f800; g = 32'h0000_07e0; b = 32'h0000_001f; a = '0;
            end
            2:
            begin
                r = 32'h0000_0f00; g = 32'h0000_00f0; b = 32'h0000_000f; a = 32'h0000_f000;
            end
            3:
            begin
                r = $urandom; g = $urandom; b = $urandom; a = $urandom;
            end
            default:
            begin
                // overlapping full masks
                r = '1; g = '1; b = '1; a = '1;
            end
        endcase
        if ($urandom_range(2) == 0)
            a = '0;
        case ($urandom_range(3))
            0:       fill = '0;
            1:       fill = '1;
            default: fill = $urandom;
        endcase
        case ($urandom_range(3))
            0:       alpha = '0;
            1:       alpha = '1;
            default: alpha = BYTE_W'($urandom);
        endcase
        apply_cfg(mode, r, g, b, a, fill, alpha, BYTE_W'($urandom));
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: 32-bit, zero weight, alpha mask clear
        send_pixel(32'h0000_0000);
        send_pixel(32'hffff_ffff);
        send_pixel(32'h1234_5678);
        drain();

        // 32-bit, full weight, alpha channel live
        apply_cfg(MODE_32BPP, 32'h00ff_0000, 32'h0000_ff00, 32'h0000_00ff, 32'hff00_0000,
                  32'hffff_ffff, 8'hff, 8'h06);
        send_pixel(32'h0000_0000);
        send_pixel(32'hffff_ffff);
        send_pixel(32'h8080_8080);
        drain();

        // 16-bit with a red mask reaching above bit 15: fill is masked at
        // full width, the sum is cut to 16 bits
        apply_cfg(MODE_16BPP, 32'h0001_f800, 32'h0000_07e0, 32'h0000_001f, 32'h0,
                  32'hffff_ffff, 8'h80, 8'h06);
        send_pixel(32'h0000_0000);
        send_pixel(32'h0000_ffff);
        send_pixel(32'hffff_0000);
        drain();

        // 24-bit, alpha on the dead lane
        apply_cfg(MODE_24BPP, 32'h00ff_0000, 32'h0000_ff00, 32'h0000_00ff, 32'h0,
                  32'h1122_3344, 8'h80, 8'he4);
        send_pixel(32'h0000_0000);
        send_pixel(32'hffff_ffff);
        send_pixel(32'ha5c3_5a00);
        drain();

        // 24-bit, all channels on lane 0: last write wins
        apply_cfg(MODE_24BPP, 32'h00ff_0000, 32'h0000_ff00, 32'h0000_00ff, 32'h0,
                  32'h0000_00ff, 8'hff, 8'h00);
        send_pixel(32'h00ff_ffff);
        send_pixel(32'hff00_0000);
        drain();

        // 24-bit, every channel on the dead lane: pixel unchanged
        apply_cfg(MODE_24BPP, 32'h00ff_0000, 32'h0000_ff00, 32'h0000_00ff, 32'h0,
                  32'hffff_ffff, 8'h40, 8'hff);
        send_pixel(32'h00ab_cdef);
        drain();

        // pass-through formats
        apply_cfg(MODE_RAW_LO, 32'h00ff_0000, 32'h0000_ff00, 32'h0000_00ff, 32'hff00_0000,
                  32'h5555_5555, 8'h80, 8'h06);
        send_pixel(32'hdead_beef);
        send_pixel(32'h0000_0000);
        drain();
        apply_cfg(MODE_RAW_HI, 32'h00ff_0000, 32'h0000_ff00, 32'h0000_00ff, 32'hff00_0000,
                  32'h5555_5555, 8'h80, 8'h06);
        send_pixel(32'hffff_ffff);
        drain();

        // 32-bit, overlapping full masks, minimum nonzero weight
        apply_cfg(MODE_32BPP, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                  32'h5a5a_5a5a, 8'h01, 8'h1b);
        send_pixel(32'hffff_ffff);
        send_pixel(32'h0000_0000);
        drain();

        // Random phases: sender light / receiver heavy idling, then swapped,
        // then none. Two phases get a long receiver hold-off.
        for (phase = 0; phase < 24; phase++)
        begin
            if (phase == 8)
            begin
                send_idle  = 59;
                recv_idle <= 12;
            end
            if (phase == 16)
            begin
                send_idle  = 0;
                recv_idle <= 0;
            end
            random_setup();
            if (phase == 2 || phase == 12)
                stall_phase <= phase;
            for (n = 0; n < 80; n++)
            begin
                case ($urandom_range(9))
                    0:       send_pixel('0);
                    1:       send_pixel('1);
                    default: send_pixel(PIX_W'($urandom));
                endcase
            end
            drain();
        end

        // wait on so that any stray result is still caught
        repeat (6) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
